### design/assert_macros.svh
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define BBA_ASSERT_IMP(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
// condition implies consequence in the following cycle
`define BBA_ASSERT_NXT(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`else
`define BBA_ASSERT_IMP(lbl, clk, rst, cond, cons, msg)
`define BBA_ASSERT_NXT(lbl, clk, rst, cond, cons, msg)
`endif
`endif

### design/bba_pkg.sv
package bba_pkg;

  localparam int MIN_BLOCK_BYTES = 128;
  localparam int MIN_SHIFT       = $clog2(MIN_BLOCK_BYTES);
  localparam int TOP_ORDER       = 10;
  localparam int TREE_COUNT      = 32;
  localparam int NODE_COUNT      = (2 << TOP_ORDER) - 1;
  localparam int UNIT_COUNT      = TREE_COUNT << TOP_ORDER;
  localparam int NODE_AW         = $clog2(NODE_COUNT);
  localparam int UNIT_AW         = $clog2(UNIT_COUNT);
  localparam int POS_W           = TOP_ORDER;
  localparam int TREE_W          = $clog2(TREE_COUNT);
  localparam int ORD_W           = 4;
  localparam int GT_W            = 4;
  localparam int CNT_W           = 16;
  localparam int HDR_W           = 7;
  localparam int HDR_RESET       = 56;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;
  localparam int SUM_W           = 19;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [PADDR_W-1:0] REG_HEADER = '0;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_NOBLOCK = 3'd1,
    STAT_ZERO    = 3'd2,
    STAT_TOOBIG  = 3'd3,
    STAT_BADFREE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECIDE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT_RD, S_SPLIT_WR,
    S_GRANT, S_LOOK_RD, S_LOOK_CHK, S_MERGE_RD, S_MERGE_CHK, S_SET_RD, S_SET_WR,
    S_RESULT
  } state_t;

  // map index of the node at (order, position)
  function automatic logic [NODE_AW-1:0] node_addr(input logic [ORD_W-1:0] order,
                                                   input logic [POS_W-1:0] pos);
    logic [NODE_AW-1:0] base;
    base = (NODE_AW'(1) << (ORD_W'(TOP_ORDER) - order)) - NODE_AW'(1);
    return base + NODE_AW'(pos);
  endfunction

endpackage

### design/bba_if.sv
// request channel
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [17:0] request_bytes;
  logic [14:0] free_address;
  modport source (output valid, kind, request_bytes, free_address, input ready);
  modport sink (input valid, kind, request_bytes, free_address, output ready);
endinterface

// response channel
interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [14:0] block_address;
  logic [3:0]  block_order;
  logic [15:0] free_block_count;
  logic [15:0] total_block_count;
  modport source (output valid, status, block_address, block_order, free_block_count,
                  total_block_count, input ready);
  modport sink (input valid, status, block_address, block_order, free_block_count,
                total_block_count, output ready);
endinterface

### design/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/buddy_block_allocator_unit.sv
// Allocate: pick the order, scan the node map, split down and grant; a zero or oversized
// request goes straight to the result. The scan reads each order tried once and the chosen
// order again, at most 2048 reads. Free: look up the granted order, merge with free buddies
// towards the root, then set the merged block; an invalid free ends after the lookup.
// Throughput: one word at a time; the next word is taken the cycle after the result registers.
// Reset: synchronous; a clearing pass zeroes the granted table, sets the map root word and zeroes the rest of the map.
`include "assert_macros.svh"
module buddy_block_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  bba_req_if.sink                       req,
  bba_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bba_pkg::PADDR_W-1:0]   paddr,
  input  logic [bba_pkg::PDATA_W-1:0]   pwdata,
  output logic [bba_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bba_pkg::*;

  state_t state, state_next;

  logic [UNIT_AW-1:0]    clr_cnt;
  logic [HDR_W-1:0]      header;
  logic [CNT_W-1:0]      free_blocks, total_blocks;
  logic [17:0]           req_bytes;
  logic [UNIT_AW-1:0]    faddr;
  logic [ORD_W-1:0]      want, ord;
  logic [TREE_W-1:0]     tree;
  logic [POS_W-1:0]      pos, scan;
  logic [TREE_COUNT-1:0] acc;
  logic                  pass;
  status_t               res_status;
  logic [UNIT_AW-1:0]    res_addr;
  logic [ORD_W-1:0]      res_order;

  logic                  out_valid;
  status_t               out_status;
  logic [UNIT_AW-1:0]    out_addr;
  logic [ORD_W-1:0]      out_order;
  logic [CNT_W-1:0]      out_free, out_total;

  // memory ports
  logic                  node_we, gt_we;
  logic [NODE_AW-1:0]    node_waddr, node_raddr;
  logic [TREE_COUNT-1:0] node_wdata, node_rdata;
  logic [UNIT_AW-1:0]    gt_waddr, gt_raddr;
  logic [GT_W-1:0]       gt_wdata, gt_rdata;

  bba_ram #(.WIDTH(TREE_COUNT), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  bba_ram #(.WIDTH(GT_W), .DEPTH(UNIT_COUNT)) u_gt_ram (
    .clk(clk), .we(gt_we), .waddr(gt_waddr), .wdata(gt_wdata),
    .raddr(gt_raddr), .rdata(gt_rdata)
  );

  // order choice
  logic [SUM_W-1:0]     need, need_m1;
  logic [SUM_W-1:0]     units_m1;
  logic                 too_big;
  logic [ORD_W-1:0]     want_c;
  always_comb begin
    need     = SUM_W'(req_bytes) + SUM_W'(header);
    need_m1  = need - SUM_W'(1);
    units_m1 = need_m1 >> MIN_SHIFT;
    too_big  = units_m1 >= (SUM_W'(1) << TOP_ORDER);
    want_c   = '0;
    for (int i = 0; i < TOP_ORDER; i++) begin
      if (units_m1[i]) begin
        want_c = ORD_W'(i + 1);
      end
    end
  end

  // scan helpers
  logic [POS_W-1:0]      scan_last;
  logic [TREE_COUNT-1:0] acc_next, tree_mask;
  logic [TREE_W-1:0]     low_tree;
  logic [POS_W-1:0]      child, buddy;
  logic [ORD_W-1:0]      gt_ord;
  logic                  gt_bad;
  always_comb begin
    scan_last = POS_W'(((POS_W+1)'(1) << (ORD_W'(TOP_ORDER) - ord)) - (POS_W+1)'(1));
    acc_next  = acc | node_rdata;
    tree_mask = TREE_COUNT'(1) << tree;
    low_tree  = '0;
    for (int i = TREE_COUNT - 1; i >= 0; i--) begin
      if (acc_next[i]) begin
        low_tree = TREE_W'(i);
      end
    end
    child  = {pos[POS_W-2:0], 1'b1};
    buddy  = pos ^ POS_W'(1);
    gt_ord = gt_rdata - GT_W'(1);
    gt_bad = (gt_rdata == '0) || (gt_rdata > GT_W'(TOP_ORDER + 1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:     if (clr_cnt == UNIT_AW'(UNIT_COUNT - 1)) state_next = S_IDLE;
      S_IDLE:      if (req.valid) state_next = (req.kind == KIND_FREE) ? S_LOOK_RD : S_DECIDE;
      S_DECIDE:    state_next = (req_bytes == '0 || too_big) ? S_RESULT : S_SCAN_RD;
      S_SCAN_RD:   state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (pass) begin
          state_next = node_rdata[tree] ? S_SPLIT_RD : S_SCAN_RD;
        end else if (scan == scan_last && acc_next == '0 && ord == ORD_W'(TOP_ORDER)) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SPLIT_RD:  state_next = (ord == want) ? S_GRANT : S_SPLIT_WR;
      S_SPLIT_WR:  state_next = S_SPLIT_RD;
      S_GRANT:     state_next = S_RESULT;
      S_LOOK_RD:   state_next = S_LOOK_CHK;
      S_LOOK_CHK:  state_next = gt_bad ? S_RESULT : S_MERGE_RD;
      S_MERGE_RD:  state_next = (ord == ORD_W'(TOP_ORDER)) ? S_SET_RD : S_MERGE_CHK;
      S_MERGE_CHK: state_next = node_rdata[tree] ? S_MERGE_RD : S_SET_RD;
      S_SET_RD:    state_next = S_SET_WR;
      S_SET_WR:    state_next = S_RESULT;
      S_RESULT:    if (!out_valid || rsp.ready) state_next = S_IDLE;
      default:     state_next = S_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    gt_we      = 1'b0;
    gt_waddr   = faddr;
    gt_wdata   = '0;
    gt_raddr   = faddr;
    unique case (state)
      S_CLEAR: begin
        gt_we      = 1'b1;
        gt_waddr   = clr_cnt;
        node_we    = clr_cnt < UNIT_AW'(NODE_COUNT);
        node_waddr = clr_cnt[NODE_AW-1:0];
        node_wdata = (clr_cnt == '0) ? '1 : '0;
      end
      S_SCAN_RD:   node_raddr = node_addr(ord, scan);
      S_SCAN_CHK: begin
        node_we    = pass && node_rdata[tree];
        node_waddr = node_addr(ord, scan);
        node_wdata = node_rdata & ~tree_mask;
      end
      S_SPLIT_RD:  node_raddr = node_addr(ord - ORD_W'(1), child);
      S_SPLIT_WR: begin
        node_we    = 1'b1;
        node_waddr = node_addr(ord, pos | POS_W'(1));
        node_wdata = node_rdata | tree_mask;
      end
      S_GRANT: begin
        gt_we    = 1'b1;
        gt_waddr = {tree, POS_W'(pos << want)};
        gt_wdata = GT_W'(want) + GT_W'(1);
      end
      S_LOOK_CHK:  gt_we = !gt_bad;
      S_MERGE_RD:  node_raddr = node_addr(ord, buddy);
      S_MERGE_CHK: begin
        node_we    = node_rdata[tree];
        node_waddr = node_addr(ord, buddy);
        node_wdata = node_rdata & ~tree_mask;
      end
      S_SET_RD:    node_raddr = node_addr(ord, pos);
      S_SET_WR: begin
        node_we    = 1'b1;
        node_waddr = node_addr(ord, pos);
        node_wdata = node_rdata | tree_mask;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      header       <= HDR_W'(HDR_RESET);
      free_blocks  <= CNT_W'(TREE_COUNT);
      total_blocks <= CNT_W'(TREE_COUNT);
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && paddr == REG_HEADER) begin
        header <= pwdata[HDR_W-1:0];
      end
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + UNIT_AW'(1);
      end
      // block counts
      unique case (state)
        S_SCAN_CHK:  if (pass && node_rdata[tree]) free_blocks <= free_blocks - CNT_W'(1);
        S_SPLIT_WR: begin
          free_blocks  <= free_blocks + CNT_W'(1);
          total_blocks <= total_blocks + CNT_W'(1);
        end
        S_MERGE_CHK: if (node_rdata[tree]) begin
          free_blocks  <= free_blocks - CNT_W'(1);
          total_blocks <= total_blocks - CNT_W'(1);
        end
        S_SET_WR:    free_blocks <= free_blocks + CNT_W'(1);
        default: ;
      endcase
      // output register
      if (state == S_RESULT && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req_bytes <= req.request_bytes;
        faddr     <= req.free_address;
      end
      S_DECIDE: begin
        want <= want_c;
        ord  <= want_c;
        scan <= '0;
        pass <= 1'b0;
        acc  <= '0;
        if (req_bytes == '0) begin
          res_status <= STAT_ZERO;
        end else begin
          res_status <= STAT_TOOBIG;
        end
        res_addr  <= '0;
        res_order <= '0;
      end
      S_SCAN_CHK: begin
        if (pass) begin
          pos  <= scan;
          scan <= scan + POS_W'(1);
        end else if (scan == scan_last) begin
          scan <= '0;
          acc  <= '0;
          if (acc_next == '0) begin
            ord        <= ord + ORD_W'(1);
            res_status <= STAT_NOBLOCK;
          end else begin
            tree <= low_tree;
            pass <= 1'b1;
          end
        end else begin
          acc  <= acc_next;
          scan <= scan + POS_W'(1);
        end
      end
      S_SPLIT_RD: begin
        if (ord != want) begin
          ord <= ord - ORD_W'(1);
          pos <= pos << 1;
        end
      end
      S_GRANT: begin
        res_status <= STAT_OK;
        res_addr   <= {tree, POS_W'(pos << want)};
        res_order  <= want;
      end
      S_LOOK_CHK: begin
        res_status <= STAT_BADFREE;
        res_addr   <= '0;
        res_order  <= '0;
        ord        <= gt_ord;
        tree       <= faddr[UNIT_AW-1:POS_W];
        pos        <= faddr[POS_W-1:0] >> gt_ord;
      end
      S_MERGE_CHK: begin
        if (node_rdata[tree]) begin
          pos <= pos >> 1;
          ord <= ord + ORD_W'(1);
        end
      end
      S_SET_WR: begin
        res_status <= STAT_OK;
        res_addr   <= {tree, POS_W'(pos << ord)};
        res_order  <= ord;
      end
      S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_status <= res_status;
          out_addr   <= res_addr;
          out_order  <= res_order;
          out_free   <= free_blocks;
          out_total  <= total_blocks;
        end
      end
      default: ;
    endcase
  end

  assign req.ready             = (state == S_IDLE);
  assign rsp.valid             = out_valid;
  assign rsp.status            = out_status;
  assign rsp.block_address     = out_addr;
  assign rsp.block_order       = out_order;
  assign rsp.free_block_count  = out_free;
  assign rsp.total_block_count = out_total;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_HEADER) ? PDATA_W'(header) : '0;

  // checker terms
  logic clear_busy, grant_aligned;
  assign clear_busy    = (state == S_CLEAR) && (clr_cnt != UNIT_AW'(UNIT_COUNT - 1));
  assign grant_aligned = (rsp.block_order <= ORD_W'(TOP_ORDER)) &&
                         ((rsp.block_address &
                           ((UNIT_AW'(1) << rsp.block_order) - UNIT_AW'(1))) == '0);

  `BBA_ASSERT_IMP(a_counts, clk, rst, state != S_CLEAR, free_blocks <= total_blocks, "free > total")
  `BBA_ASSERT_IMP(a_aligned, clk, rst, rsp.valid && rsp.status == STAT_OK, grant_aligned, "misaligned")
  `BBA_ASSERT_NXT(a_clear_blocks, clk, rst, clear_busy, !req.ready, "word taken while clearing")
endmodule

### test/tb_buddy_block_allocator_unit.sv
module tb_buddy_block_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int NODES  = (2 << TOP_ORDER) - 1;
  localparam int UNITS  = TREE_COUNT << TOP_ORDER;
  localparam int WORDS  = 1750;

  typedef struct packed {
    status_t     status;
    logic [14:0] block_address;
    logic [3:0]  block_order;
    logic [15:0] free_block_count;
    logic [15:0] total_block_count;
  } outcome_t;

  typedef struct {
    logic        kind;
    int          bytes;
    int          addr;
    bit          typed;
    outcome_t    outcome;
  } stim_row_t;

  typedef struct {
    bit       typed;
    outcome_t outcome;
  } typed_note_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bba_req_if req ();
  bba_rsp_if rsp ();

  buddy_block_allocator_unit i_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.kind = KIND_ALLOC;
    req.request_bytes = '0;
    req.free_address = '0;
    rsp.ready = 1'b0;
  end

  // allocator state as the block should hold it
  bit [31:0]   free_map [NODES];
  bit [3:0]    granted_order [UNITS];
  int unsigned free_blocks_now, total_blocks_now;
  logic [6:0]  header_now;

  outcome_t     expected_q [$];
  typed_note_t  typed_q [$];
  int           live_blocks [$];
  int           recent_frees [$];
  int           mismatches = 0;
  int           words_in = 0, words_out = 0;
  int           status_seen [5];
  bit           long_hold = 0;
  bit           no_gaps = 0;

  function automatic int node_index(int order, int pos);
    return ((1 << (TOP_ORDER - order)) - 1) + pos;
  endfunction

  function automatic outcome_t make_outcome(status_t st, int addr, int order);
    outcome_t r;
    r.status = st;
    r.block_address = addr[14:0];
    r.block_order = order[3:0];
    r.free_block_count = free_blocks_now[15:0];
    r.total_block_count = total_blocks_now[15:0];
    return r;
  endfunction

  function automatic outcome_t grant_block(int bytes);
    int need, want, span, pos;
    need = bytes + header_now;
    if (bytes == 0) return make_outcome(STAT_ZERO, 0, 0);
    want = 0;
    while (want <= TOP_ORDER && (MIN_BLOCK_BYTES << want) < need) want++;
    if (want > TOP_ORDER) return make_outcome(STAT_TOOBIG, 0, 0);
    for (int o = want; o <= TOP_ORDER; o++) begin
      span = 1 << (TOP_ORDER - o);
      for (int t = 0; t < TREE_COUNT; t++) begin
        for (int p = 0; p < span; p++) begin
          if (free_map[node_index(o, p)][t]) begin
            free_map[node_index(o, p)][t] = 1'b0;
            pos = p;
            // split down, right halves stay free
            for (int k = o; k > want; k--) begin
              pos = pos << 1;
              free_map[node_index(k - 1, pos + 1)][t] = 1'b1;
            end
            free_blocks_now = free_blocks_now - 1 + (o - want);
            total_blocks_now += o - want;
            granted_order[(t << TOP_ORDER) + (pos << want)] = 4'(want + 1);
            return make_outcome(STAT_OK, (t << TOP_ORDER) + (pos << want), want);
          end
        end
      end
    end
    return make_outcome(STAT_NOBLOCK, 0, 0);
  endfunction

  function automatic outcome_t release_block(int addr);
    int order, t, p;
    if (granted_order[addr] == 0 || granted_order[addr] > TOP_ORDER + 1)
      return make_outcome(STAT_BADFREE, 0, 0);
    order = granted_order[addr] - 1;
    granted_order[addr] = 0;
    t = addr >> TOP_ORDER;
    p = (addr & ((1 << TOP_ORDER) - 1)) >> order;
    // merge with free buddies towards the root
    while (order < TOP_ORDER && free_map[node_index(order, p ^ 1)][t]) begin
      free_map[node_index(order, p ^ 1)][t] = 1'b0;
      free_blocks_now--;
      total_blocks_now--;
      p = p >> 1;
      order++;
    end
    free_map[node_index(order, p)][t] = 1'b1;
    free_blocks_now++;
    return make_outcome(STAT_OK, (t << TOP_ORDER) + (p << order), order);
  endfunction

  initial begin
    foreach (free_map[i]) free_map[i] = '0;
    foreach (granted_order[i]) granted_order[i] = '0;
    free_map[0] = '1;
    free_blocks_now = TREE_COUNT;
    total_blocks_now = TREE_COUNT;
    header_now = 7'(HDR_RESET);
  end

  // predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    typed_note_t note;
    outcome_t    want_r, got;
    if (!rst) begin
      if (req.valid && req.ready) begin
        note.typed = 0;
        if (typed_q.size() > 0) note = typed_q.pop_front();
        if (req.kind == KIND_ALLOC) want_r = grant_block(int'(req.request_bytes));
        else want_r = release_block(int'(req.free_address));
        if (req.kind == KIND_ALLOC && want_r.status == STAT_OK)
          live_blocks.push_back(int'(want_r.block_address));
        if (note.typed) want_r = note.outcome;
        expected_q.push_back(want_r);
        words_in++;
      end
      if (rsp.valid && rsp.ready) begin
        got.status = status_t'(rsp.status);
        got.block_address = rsp.block_address;
        got.block_order = rsp.block_order;
        got.free_block_count = rsp.free_block_count;
        got.total_block_count = rsp.total_block_count;
        words_out++;
        if (rsp.status <= 3'd4) status_seen[rsp.status]++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response word: %p", got);
        end else begin
          want_r = expected_q.pop_front();
          if (got !== want_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at response %0d: expected %p, got %p",
                       words_out, want_r, got);
          end
        end
      end
    end
  end

  // response side back-pressure
  initial begin
    int on_len, gap;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      rsp.ready <= 1'b1;
      on_len = $urandom_range(1, 40);
      repeat (on_len) @(posedge clk);
      if (!no_gaps) begin
        gap = $urandom_range(0, 99);
        gap = gap < 60 ? 0 : gap < 92 ? $urandom_range(1, 3) :
              gap < 98 ? $urandom_range(4, 15) : $urandom_range(30, 120);
        if (gap > 0) begin
          rsp.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #400ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic write_header(int value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_HEADER; pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    header_now = 7'(value);
  endtask

  task automatic wait_drained();
    while (expected_q.size() > 0 || typed_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_word(logic kind, int bytes, int addr, bit typed, outcome_t o);
    typed_note_t note;
    int gap;
    note.typed = typed;
    note.outcome = o;
    typed_q.push_back(note);
    req.kind <= kind;
    req.request_bytes <= 18'(bytes);
    req.free_address <= 15'(addr);
    req.valid <= 1'b1;
    @(negedge clk);
    while (!req.ready) @(negedge clk);
    @(posedge clk);
    gap = $urandom_range(0, 99);
    gap = (no_gaps || gap < 55) ? 0 : gap < 90 ? $urandom_range(1, 3) :
          gap < 98 ? $urandom_range(4, 12) : $urandom_range(30, 100);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic outcome_t typed(status_t st, int a, int o, int fc, int tc);
    outcome_t r;
    r.status = st; r.block_address = a[14:0]; r.block_order = o[3:0];
    r.free_block_count = fc[15:0]; r.total_block_count = tc[15:0];
    return r;
  endfunction

  // one random word: mostly well-formed allocate and free, some noise
  task automatic random_word();
    int r, o, idx, a;
    outcome_t none;
    none = '0;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_word(1'($urandom), $urandom_range(0, 262143), $urandom_range(0, 32767), 0, none);
    end else if (r < 9 && recent_frees.size() > 0) begin
      send_word(KIND_FREE, $urandom_range(0, 262143),
                recent_frees[$urandom_range(0, recent_frees.size() - 1)], 0, none);
    end else if (live_blocks.size() > 0 && (r < 50 || live_blocks.size() > 48)) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[idx];
      live_blocks.delete(idx);
      recent_frees.push_back(a);
      if (recent_frees.size() > 16) void'(recent_frees.pop_front());
      send_word(KIND_FREE, $urandom_range(0, 262143), a, 0, none);
    end else begin
      // small orders make long scans, keep them rare
      o = ($urandom_range(0, 99) < 4) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      send_word(KIND_ALLOC, $urandom_range(1, MIN_BLOCK_BYTES << o),
                $urandom_range(0, 32767), 0, none);
    end
  endtask

  stim_row_t rows [] ;
  int header_plan [4] = '{0, 127, -1, 56};

  initial begin
    outcome_t none;
    none = '0;
    rows = new[18];
    rows[0]  = '{KIND_ALLOC, 0,      0,     1, typed(STAT_ZERO, 0, 0, 32, 32)};
    rows[1]  = '{KIND_ALLOC, 131072, 0,     1, typed(STAT_TOOBIG, 0, 0, 32, 32)};
    rows[2]  = '{KIND_ALLOC, 131016, 32767, 1, typed(STAT_OK, 0, 10, 31, 32)};
    rows[3]  = '{KIND_FREE,  262143, 0,     1, typed(STAT_OK, 0, 10, 32, 32)};
    rows[4]  = '{KIND_FREE,  0,      0,     1, typed(STAT_BADFREE, 0, 0, 32, 32)};
    rows[5]  = '{KIND_FREE,  0,      32767, 1, typed(STAT_BADFREE, 0, 0, 32, 32)};
    rows[6]  = '{KIND_ALLOC, 1,      0,     1, typed(STAT_OK, 0, 0, 41, 42)};
    rows[7]  = '{KIND_FREE,  0,      5,     1, typed(STAT_BADFREE, 0, 0, 41, 42)};
    rows[8]  = '{KIND_ALLOC, 72,     0,     0, none};
    rows[9]  = '{KIND_ALLOC, 73,     0,     0, none};
    rows[10] = '{KIND_ALLOC, 262143, 0,     1, typed(STAT_TOOBIG, 0, 0, 39, 42)};
    rows[11] = '{KIND_ALLOC, 131017, 0,     1, typed(STAT_TOOBIG, 0, 0, 39, 42)};
    rows[12] = '{KIND_FREE,  0,      1,     0, none};
    rows[13] = '{KIND_FREE,  0,      0,     0, none};
    rows[14] = '{KIND_FREE,  0,      2,     0, none};
    rows[15] = '{KIND_ALLOC, 65000,  16383, 0, none};
    rows[16] = '{KIND_FREE,  0,      31744, 0, none};
    rows[17] = '{KIND_ALLOC, 4000,   21845, 0, none};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the reset header size
    foreach (rows[i])
      send_word(rows[i].kind, rows[i].bytes, rows[i].addr, rows[i].typed, rows[i].outcome);
    req.valid <= 1'b0;
    live_blocks.delete();
    wait_drained();

    // header 127: 33 order-0 blocks, then 33 top-order for 32 trees
    write_header(127);
    for (int i = 0; i <= TREE_COUNT; i++) send_word(KIND_ALLOC, 1, 0, 0, none);
    for (int i = 0; i < TREE_COUNT; i++) send_word(KIND_ALLOC, 131072 - 127, 0, 0, none);
    send_word(KIND_ALLOC, 131072 - 127, 0, 0, none);
    req.valid <= 1'b0;
    wait_drained();

    // random phases, each at its own header size
    foreach (header_plan[ph]) begin
      write_header(header_plan[ph] < 0 ? $urandom_range(1, 126) : header_plan[ph]);
      for (int n = 0; n < WORDS / 4; n++) begin
        if (ph == 1 && n == 60) long_hold = 1;
        no_gaps = (ph == 2 && n >= 100 && n < 200);
        random_word();
      end
      no_gaps = 0;
      req.valid <= 1'b0;
      wait_drained();
    end

    $display("%0d request words, %0d responses: ok %0d, no block %0d, zero %0d,",
             words_in, words_out, status_seen[0], status_seen[1], status_seen[2]);
    $display("too big %0d, invalid free %0d; header sizes 56, 127, 0, random and 56",
             status_seen[3], status_seen[4]);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatches, expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
